// ===== src/assert_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_AT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== src/u2u8_pkg.sv =====
// Shared types, constants and UTF-8 byte builders for the UTF-16 to UTF-8 converter.
`timescale 1ns / 1ps
package u2u8_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int CU_W           = 16;
	localparam int BYTE_W         = 8;
	localparam int REP_W          = 16;
	localparam int CAP_W          = 16;
	localparam int MAX_RES        = 7;
	localparam int RES_CNT_W      = 3;
	localparam int SUR_W          = 10;
	localparam int CP_W           = 21;
	localparam int TDATA_IN_W     = 16;
	localparam int TDATA_OUT_W    = 48;

	localparam logic [CAP_W-1:0] CAP_RESET = 16'd255;
	localparam logic [5:0] HIGH_TAG = 6'b110110;
	localparam logic [5:0] LOW_TAG  = 6'b110111;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SRC_EXH  = 2'd1,
		ST_TGT_EXH  = 2'd2,
		ST_ILLEGAL  = 2'd3
	} status_t;

	typedef enum logic {
		REG_STRICT_MODE  = 1'b0,
		REG_OUT_CAPACITY = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CU_W-1:0] code_unit;
		logic            last_unit;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              string_done;
		status_t           status_code;
		logic [REP_W-1:0]  units_consumed;
		logic [REP_W-1:0]  bytes_written;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0]   ent;
		logic [RES_CNT_W-1:0] n;
	} burst_t;

	// Byte count of a code point below 0x10000.
	function automatic logic [1:0] bmp_len(input logic [CU_W-1:0] cp);
		if (cp < 16'h0080) begin
			bmp_len = 2'd1;
		end else if (cp < 16'h0800) begin
			bmp_len = 2'd2;
		end else begin
			bmp_len = 2'd3;
		end
	endfunction

	// Bytes of a code point below 0x10000, lead byte in element 0.
	function automatic logic [2:0][BYTE_W-1:0] utf8_bmp(input logic [CU_W-1:0] cp);
		logic [2:0][BYTE_W-1:0] b;
		b = '0;
		if (cp < 16'h0080) begin
			b[0] = cp[7:0];
		end else if (cp < 16'h0800) begin
			b[0] = {3'b110, cp[10:6]};
			b[1] = {2'b10, cp[5:0]};
		end else begin
			b[0] = {4'b1110, cp[15:12]};
			b[1] = {2'b10, cp[11:6]};
			b[2] = {2'b10, cp[5:0]};
		end
		utf8_bmp = b;
	endfunction

	// Four bytes of a supplementary code point, lead byte in element 0.
	function automatic logic [3:0][BYTE_W-1:0] utf8_supp(input logic [CP_W-1:0] cp);
		logic [3:0][BYTE_W-1:0] b;
		b[0] = {5'b11110, cp[20:18]};
		b[1] = {2'b10, cp[17:12]};
		b[2] = {2'b10, cp[11:6]};
		b[3] = {2'b10, cp[5:0]};
		utf8_supp = b;
	endfunction

endpackage

// ===== src/u2u8_instage.sv =====
// Input register stage: holds one accepted code unit until the converter takes it.
`timescale 1ns / 1ps
module u2u8_instage import u2u8_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_IN_W-1:0] s_tdata,
	input  logic                  s_tlast,
	input  logic                  take,
	output logic                  item_valid,
	output item_t                 item
);

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	// Free when empty or when the held word leaves this cycle
	assign s_tready   = !valid_s1 || take;
	assign accept     = s_tvalid && s_tready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the word
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.code_unit <= s_tdata[CU_W-1:0];
			item_s1.last_unit <= s_tlast;
		end
	end

endmodule

// ===== src/u2u8_conv.sv =====
// Converter core: surrogate pairing, UTF-8 encoding, capacity check and string state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module u2u8_conv import u2u8_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             strict_mode,
	input  logic [CAP_W-1:0] out_capacity,
	input  logic             item_valid,
	input  item_t            item,
	output logic             take,
	input  logic             buf_free,
	output logic             load,
	output burst_t           burst
);

	localparam int EXT_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;

	logic [SUR_W-1:0]      ph_q, ph_d;
	logic                  pv_q, pv_d;
	logic [COUNT_BITS-1:0] bc_q, bc_d;
	logic [COUNT_BITS-1:0] uc_q, uc_d;
	logic                  halted_q, halted_d;

	logic [3:0][BYTE_W-1:0] a_bytes;
	logic [2:0]             na;
	logic [2:0][BYTE_W-1:0] b_bytes;
	logic [1:0]             nb;
	logic                   close;
	status_t                cl_stat;
	logic [COUNT_BITS-1:0]  cl_uc, cl_bc;
	logic [RES_CNT_W-1:0]   n_res;
	logic                   proc;

	// Add a small amount, clamping at the counter's top value
	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
	                                                   input logic [2:0] n);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + (COUNT_BITS+1)'(n);
		if (s[COUNT_BITS]) begin
			sat_add = '1;
		end else begin
			sat_add = s[COUNT_BITS-1:0];
		end
	endfunction

	// True when n more bytes stay within capacity
	function automatic logic fits(input logic [COUNT_BITS-1:0] a, input logic [2:0] n,
	                              input logic [CAP_W-1:0] cap);
		fits = (EXT_W'(a) + EXT_W'(n)) <= EXT_W'(cap);
	endfunction

	// Decode one unit into its result burst and next state
	always_comb begin : conv_logic
		logic [CU_W-1:0]       cu;
		logic                  last;
		logic                  is_high, is_low;
		logic                  stop, clear, go;
		logic [COUNT_BITS-1:0] bc1, uc1, bc2, uc2;
		logic [CP_W-1:0]       cp4;
		logic [1:0]            n_cu;
		cu      = item.code_unit;
		last    = item.last_unit;
		is_high = (cu[15:10] == HIGH_TAG);
		is_low  = (cu[15:10] == LOW_TAG);
		ph_d     = ph_q;
		pv_d     = pv_q;
		bc_d     = bc_q;
		uc_d     = uc_q;
		halted_d = halted_q;
		a_bytes  = '0;
		na       = 3'd0;
		b_bytes  = '0;
		nb       = 2'd0;
		close    = 1'b0;
		cl_stat  = ST_OK;
		cl_uc    = uc_q;
		cl_bc    = bc_q;
		stop     = 1'b0;
		clear    = 1'b0;
		go       = 1'b1;
		bc1      = bc_q;
		uc1      = uc_q;
		bc2      = bc_q;
		uc2      = uc_q;
		n_cu     = bmp_len(cu);
		cp4      = {1'b0, ph_q, cu[SUR_W-1:0]} + SUPP_BASE;

		priority if (halted_q) begin
			// Drop words until the end of the string
			clear = last;
		end else if (pv_q && is_low) begin
			// Join the pair into one supplementary code point
			if (!fits(bc_q, 3'd4, out_capacity)) begin
				stop    = 1'b1;
				close   = 1'b1;
				cl_stat = ST_TGT_EXH;
			end else begin
				a_bytes = utf8_supp(cp4);
				na      = 3'd4;
				bc1     = sat_add(bc_q, 3'd4);
				uc1     = sat_add(uc_q, 3'd2);
				pv_d    = 1'b0;
				ph_d    = '0;
				bc_d    = bc1;
				uc_d    = uc1;
				if (last) begin
					close = 1'b1;
					cl_uc = uc1;
					cl_bc = bc1;
					clear = 1'b1;
				end
			end
		end else if (pv_q && strict_mode) begin
			// Unpaired high surrogate
			stop    = 1'b1;
			close   = 1'b1;
			cl_stat = ST_ILLEGAL;
		end else begin
			// Flush an unpaired high surrogate as three bytes
			if (pv_q) begin
				if (!fits(bc_q, 3'd3, out_capacity)) begin
					stop    = 1'b1;
					close   = 1'b1;
					cl_stat = ST_TGT_EXH;
					go      = 1'b0;
				end else begin
					a_bytes[2:0] = utf8_bmp({HIGH_TAG, ph_q});
					na           = 3'd3;
					bc1          = sat_add(bc_q, 3'd3);
					uc1          = sat_add(uc_q, 3'd1);
					pv_d         = 1'b0;
					ph_d         = '0;
					bc_d         = bc1;
					uc_d         = uc1;
				end
			end
			cl_uc = uc1;
			cl_bc = bc1;
			// Handle the current unit on its own
			if (go) begin
				priority if (is_high) begin
					if (last) begin
						stop    = 1'b1;
						close   = 1'b1;
						cl_stat = ST_SRC_EXH;
					end else begin
						pv_d = 1'b1;
						ph_d = cu[SUR_W-1:0];
					end
				end else if (is_low && strict_mode) begin
					stop    = 1'b1;
					close   = 1'b1;
					cl_stat = ST_ILLEGAL;
				end else if (!fits(bc1, {1'b0, n_cu}, out_capacity)) begin
					stop    = 1'b1;
					close   = 1'b1;
					cl_stat = ST_TGT_EXH;
				end else begin
					b_bytes = utf8_bmp(cu);
					nb      = n_cu;
					bc2     = sat_add(bc1, {1'b0, n_cu});
					uc2     = sat_add(uc1, 3'd1);
					bc_d    = bc2;
					uc_d    = uc2;
					if (last) begin
						close = 1'b1;
						cl_uc = uc2;
						cl_bc = bc2;
						clear = 1'b1;
					end
				end
			end
		end

		// Stop the string: drop any held surrogate
		if (stop) begin
			pv_d = 1'b0;
			ph_d = '0;
			if (last) begin
				clear = 1'b1;
			end else begin
				halted_d = 1'b1;
			end
		end

		if (clear) begin
			ph_d     = '0;
			pv_d     = 1'b0;
			bc_d     = '0;
			uc_d     = '0;
			halted_d = 1'b0;
		end
	end

	// Lay out the burst: held-surrogate bytes, current bytes, closing word
	always_comb begin : burst_build
		res_t closing;
		int   j;
		closing.out_byte       = '0;
		closing.byte_valid     = 1'b0;
		closing.string_done    = 1'b1;
		closing.status_code    = cl_stat;
		closing.units_consumed = REP_W'(cl_uc);
		closing.bytes_written  = REP_W'(cl_bc);
		j = 0;
		for (int i = 0; i < MAX_RES; i++) begin
			burst.ent[i] = closing;
			if (i < int'(na)) begin
				burst.ent[i]                = '0;
				burst.ent[i].out_byte       = a_bytes[i[1:0]];
				burst.ent[i].byte_valid     = 1'b1;
			end else if (i < int'(na) + int'(nb)) begin
				j = i - int'(na);
				burst.ent[i]                = '0;
				burst.ent[i].out_byte       = b_bytes[j[1:0]];
				burst.ent[i].byte_valid     = 1'b1;
			end
		end
		n_res   = na + RES_CNT_W'(nb) + RES_CNT_W'(close);
		burst.n = n_res;
	end

	// Take a unit when the result buffer is free or it gives nothing
	assign proc = item_valid && (buf_free || (n_res == '0));
	assign take = proc;
	assign load = proc && (n_res != '0);

	// Update string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= '0;
			pv_q     <= 1'b0;
			bc_q     <= '0;
			uc_q     <= '0;
			halted_q <= 1'b0;
		end else if (proc) begin
			ph_q     <= ph_d;
			pv_q     <= pv_d;
			bc_q     <= bc_d;
			uc_q     <= uc_d;
			halted_q <= halted_d;
		end
	end

	`ASSERT_NEVER(a_halt_pend, clk, arst_n, halted_q && pv_q,
		"surrogate held while the string is stopped")
	`ASSERT_AT(a_burst_max, clk, arst_n, !proc || (int'(na) + int'(nb) + int'(close) <= MAX_RES),
		"burst longer than the buffer")
	`ASSERT_AT(a_halt_quiet, clk, arst_n, !(proc && halted_q) || (n_res == '0),
		"stopped string produced output")

endmodule

// ===== src/u2u8_burst.sv =====
// Result buffer: holds one unit's burst and hands it out one word per cycle while m_ready is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module u2u8_burst import u2u8_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  burst_t burst,
	output logic   buf_free,
	output logic   m_valid,
	input  logic   m_ready,
	output res_t   head
);

	res_t [MAX_RES-1:0]   buf_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 pop;

	assign pop      = (cnt_q != '0) && m_ready;
	assign buf_free = (cnt_q == '0) || ((cnt_q == RES_CNT_W'(1)) && m_ready);
	assign m_valid  = (cnt_q != '0);
	assign head     = buf_q[0];

	// Track the number of words left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.n;
		end else if (pop) begin
			cnt_q <= cnt_q - RES_CNT_W'(1);
		end
	end

	// Load a fresh burst or advance to the next word
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= burst.ent;
		end else if (pop) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	`ASSERT_AT(a_load_free, clk, arst_n, !load || buf_free, "burst loaded over pending words")
	`ASSERT_AT(a_close_last, clk, arst_n, !(m_valid && head.string_done) || (cnt_q == RES_CNT_W'(1)),
		"closing word is not the last of its burst")
	`ASSERT_AT(a_cnt_range, clk, arst_n, cnt_q <= RES_CNT_W'(MAX_RES), "word count out of range")

endmodule

// ===== src/utf16_to_utf8_encoder.sv =====
// Top level of the streaming UTF-16 to UTF-8 converter with its register file.
// Usage:
//   Slave channel: one UTF-16 code unit per word in s_tdata[15:0]; s_tlast
//   marks the final unit of a string.
//   Master channel: one result word per handshake. A byte word carries a
//   UTF-8 byte (m_tuser = 1); the closing word of a string (m_tlast = 1,
//   m_tuser = 0) carries status, units consumed and bytes written.
//   Registers: index 0 strict mode, index 1 output capacity in bytes; write
//   them only while no string is in flight.
// A unit is accepted into the input register, converted combinationally and
// its burst loaded into the result buffer, which offers its first result word;
// a busy buffer holds the unit in the input register. Throughput: a unit
// produces up to seven result words (a flushed surrogate, a three-byte
// character and the closing word); the result buffer, drained one word per
// cycle while m_tready is high, takes a new burst once empty or as its last word leaves.
// Reset clears all string state and loads strict mode 0 and capacity 255; a
// stalled receiver holds the result word, and the input register accepts one
// more unit before s_tready falls.
`timescale 1ns / 1ps
module utf16_to_utf8_encoder import u2u8_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,   // [15:0] code_unit
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,   // [7:0] out_byte, [9:8] status_code,
	                                          // [25:10] units_consumed,
	                                          // [41:26] bytes_written, [47:42] zero
	output logic                   m_tuser,   // [0] byte_valid
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_addr,
	input  logic [CAP_W-1:0]       cfg_wdata
);

	localparam int PAD_W = TDATA_OUT_W - (BYTE_W + 2 + 2 * REP_W);

	logic             strict_q;
	logic [CAP_W-1:0] cap_q;
	logic             item_valid;
	item_t            item;
	logic             take;
	logic             buf_free;
	logic             load;
	burst_t           burst;
	res_t             head;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
			cap_q    <= CAP_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_STRICT_MODE:  strict_q <= cfg_wdata[0];
				REG_OUT_CAPACITY: cap_q    <= cfg_wdata;
				default:          cap_q    <= cap_q;
			endcase
		end
	end

	u2u8_instage u_instage (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	u2u8_conv #(
		.COUNT_BITS (COUNT_BITS)
	) u_conv (
		.clk          (clk),
		.arst_n       (arst_n),
		.strict_mode  (strict_q),
		.out_capacity (cap_q),
		.item_valid   (item_valid),
		.item         (item),
		.take         (take),
		.buf_free     (buf_free),
		.load         (load),
		.burst        (burst)
	);

	u2u8_burst u_burst (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.burst    (burst),
		.buf_free (buf_free),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.head     (head)
	);

	// Pack the result word
	assign m_tdata = {{PAD_W{1'b0}}, head.bytes_written, head.units_consumed,
	                  head.status_code, head.out_byte};
	assign m_tuser = head.byte_valid;
	assign m_tlast = head.string_done;

endmodule
